### hw/rtl/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer package
// Shared types, byte-class constants and decode helpers of the sanitizer.
// ----------------------------------------------------------------------------
package utf8s_pkg;

   // Most output bytes that one input byte can cause.
   localparam int MaxOut = 6;

   // Bytes of U+FFFD in UTF-8.
   localparam logic [7:0] REPL_B0 = 8'hEF;
   localparam logic [7:0] REPL_B1 = 8'hBF;
   localparam logic [7:0] REPL_B2 = 8'hBD;

   // Lead byte class boundaries.
   localparam logic [7:0] LEAD2_LO   = 8'hC2;
   localparam logic [7:0] LEAD3_LO   = 8'hE0;
   localparam logic [7:0] LEAD4_LO   = 8'hF0;
   localparam logic [7:0] LEAD_LIMIT = 8'hF5;

   // Continuation byte range and the leads that narrow it.
   localparam logic [7:0] CONT_LO      = 8'h80;
   localparam logic [7:0] CONT_HI      = 8'hBF;
   localparam logic [7:0] LEAD_E0      = 8'hE0;
   localparam logic [7:0] LEAD_ED      = 8'hED;
   localparam logic [7:0] LEAD_F0      = 8'hF0;
   localparam logic [7:0] LEAD_F4      = 8'hF4;
   localparam logic [7:0] E0_SECOND_LO = 8'hA0;
   localparam logic [7:0] ED_SECOND_HI = 8'h9F;
   localparam logic [7:0] F0_SECOND_LO = 8'h90;
   localparam logic [7:0] F4_SECOND_HI = 8'h8F;

   // One queued group of output bytes, all caused by a single input byte.
   typedef struct packed {
      logic [MaxOut-1:0][7:0] bytes;
      logic [2:0]             count;
      logic                   last;
   } entry_type;

   // Full sequence length led by b, or zero when b cannot lead.
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if (b < CONT_LO) begin
         len = 3'd1;
      end else if (b < LEAD2_LO) begin
         len = 3'd0;
      end else if (b < LEAD3_LO) begin
         len = 3'd2;
      end else if (b < LEAD4_LO) begin
         len = 3'd3;
      end else if (b < LEAD_LIMIT) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   // Whether c may follow the given lead as its second byte.
   function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = CONT_LO;
      hi = CONT_HI;
      unique case (lead)
         LEAD_E0: lo = E0_SECOND_LO;
         LEAD_ED: hi = ED_SECOND_HI;
         LEAD_F0: lo = F0_SECOND_LO;
         LEAD_F4: hi = F4_SECOND_HI;
         default: ;
      endcase
      return (c >= lo) && (c <= hi);
   endfunction

endpackage

### hw/rtl/utf8s_if.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer channels
// Valid/ready channels for raw input bytes and sanitized output bytes.
// ----------------------------------------------------------------------------
interface utf8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       text_last;

   modport source (output valid, output in_byte, output text_last, input ready);
   modport sink   (input valid, input in_byte, input text_last, output ready);
endinterface

interface utf8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       text_end;

   modport source (output valid, output out_byte, output run_end, output text_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_end, input text_end,
                   output ready);
endinterface

### hw/rtl/utf8s_front.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer front end
// Accepts raw bytes, tracks the pending partial sequence and turns each
// input byte into at most one group of output bytes for the queue.
// ----------------------------------------------------------------------------
module utf8s_front
   import utf8s_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   utf8s_req_if.sink          req_chan,
   output entry_type          push_entry,
   output logic               push_valid,
   input  logic               push_ready
);

   logic [2:0][7:0] held_ff;
   logic [2:0][7:0] held_in;
   logic [1:0]      cnt_ff;
   logic [1:0]      cnt_in;
   logic [2:0]      len_ff;
   logic [2:0]      len_in;

   logic                   accept;
   logic                   cont_ok;
   logic                   do_lead;
   logic [2:0]             lead_n;
   logic [MaxOut-1:0][7:0] ob;
   logic [2:0]             on;
   logic [7:0]             b;

   assign b        = req_chan.in_byte;
   assign accept   = req_chan.valid && push_ready;
   assign req_chan.ready = push_ready;

   // The second byte depends on the lead; later ones are plain continuations.
   assign cont_ok = (cnt_ff == 2'd1) ? second_ok(held_ff[0], b)
                                     : ((b >= CONT_LO) && (b <= CONT_HI));
   assign lead_n  = lead_len(b);

   // Decode one byte against the pending sequence and collect its output.
   always_comb begin
      ob      = '0;
      on      = '0;
      held_in = held_ff;
      cnt_in  = cnt_ff;
      len_in  = len_ff;
      do_lead = 1'b0;

      if (cnt_ff == 2'd0) begin
         do_lead = 1'b1;
      end else if (!cont_ok) begin
         // The held bytes form one ill-formed subpart; the byte starts afresh.
         ob[on] = REPL_B0; on = on + 3'd1;
         ob[on] = REPL_B1; on = on + 3'd1;
         ob[on] = REPL_B2; on = on + 3'd1;
         cnt_in  = '0;
         len_in  = '0;
         do_lead = 1'b1;
      end else if (({1'b0, cnt_ff} + 3'd1) >= len_ff) begin
         // Sequence complete: release the held bytes and this one.
         for (int k = 0; k < 3; k++) begin
            if (k < int'(cnt_ff)) begin
               ob[on] = held_ff[k];
               on     = on + 3'd1;
            end
         end
         ob[on] = b; on = on + 3'd1;
         cnt_in = '0;
         len_in = '0;
      end else begin
         held_in[cnt_ff] = b;
         cnt_in          = cnt_ff + 2'd1;
      end

      if (do_lead) begin
         if (lead_n == 3'd0) begin
            ob[on] = REPL_B0; on = on + 3'd1;
            ob[on] = REPL_B1; on = on + 3'd1;
            ob[on] = REPL_B2; on = on + 3'd1;
         end else if (lead_n == 3'd1) begin
            ob[on] = b; on = on + 3'd1;
         end else begin
            held_in[0] = b;
            cnt_in     = 2'd1;
            len_in     = lead_n;
         end
      end

      // A sequence still open at the end of the text is truncated.
      if (req_chan.text_last && (cnt_in != 2'd0)) begin
         ob[on] = REPL_B0; on = on + 3'd1;
         ob[on] = REPL_B1; on = on + 3'd1;
         ob[on] = REPL_B2; on = on + 3'd1;
         cnt_in = '0;
         len_in = '0;
      end
   end

   assign push_entry.bytes = ob;
   assign push_entry.count = on;
   assign push_entry.last  = req_chan.text_last;
   assign push_valid       = accept && (on != 3'd0);

   // Pending sequence state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         len_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         len_ff <= len_in;
      end
   end

   // Held bytes need no reset; only entries below the count are read.
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   a_len_covers_held: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> ({1'b0, cnt_ff} < len_ff) && (len_ff >= 3'd2))
      else $error("pending length does not exceed held count");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.text_last) |=> (cnt_ff == 2'd0) && (len_ff == 3'd0))
      else $error("sequence still pending after final byte");

endmodule

### hw/rtl/utf8s_fifo.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer queue
// Short queue of output byte groups between the front and back ends.
// ----------------------------------------------------------------------------
module utf8s_fifo
   import utf8s_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  entry_type push_entry,
   input  logic      push_valid,
   output logic      push_ready,
   output entry_type head_entry,
   output logic      head_valid,
   input  logic      pop
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   entry_type           mem_ff [DEPTH];
   logic [PtrW-1:0]     wr_ff;
   logic [PtrW-1:0]     wr_in;
   logic [PtrW-1:0]     rd_ff;
   logic [PtrW-1:0]     rd_in;
   logic [CntW-1:0]     cnt_ff;
   logic [CntW-1:0]     cnt_in;
   logic                do_push;

   assign push_ready = (cnt_ff != CntW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      if (do_push && !pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage is written at the tail only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule

### hw/rtl/utf8s_back.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer back end
// Sends the bytes of the head queue entry one per transaction and marks
// the run and text ends.
// ----------------------------------------------------------------------------
module utf8s_back
   import utf8s_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head_entry,
   input  logic       head_valid,
   output logic       pop,
   utf8s_rsp_if.source rsp_chan
);

   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       is_fin;
   logic       fire;

   assign is_fin = (idx_ff == (head_entry.count - 3'd1));
   assign fire   = rsp_chan.valid && rsp_chan.ready;
   assign pop    = fire && is_fin;

   assign rsp_chan.valid    = head_valid;
   assign rsp_chan.out_byte = head_entry.bytes[idx_ff];
   assign rsp_chan.run_end  = is_fin;
   assign rsp_chan.text_end = is_fin && head_entry.last;

   // Byte index within the head entry.
   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = is_fin ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_idx_in_entry: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head_entry.count))
      else $error("byte index past end of entry");

endmodule

### hw/rtl/utf8_sanitizer_core.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer core
// Streaming UTF-8 validator that replaces each maximal ill-formed subpart
// with U+FFFD.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one raw byte per transaction, with text_last on the
//   final byte of a text. rsp_chan carries sanitized bytes, one per
//   transaction; run_end marks the last byte caused by one input byte and
//   text_end the last byte of the text. A byte that only extends a pending
//   sequence causes no response transaction.
//   The bytes caused by an input byte are registered in the queue before
//   the back end sends them. Throughput: one input byte per cycle while
//   each causes at most one output byte and the receiver is ready. The
//   back end sends one byte per cycle while the receiver is ready, so an
//   input byte that causes n bytes (up to 6) occupies the output for n
//   transactions; the queue of QUEUE_DEPTH entries absorbs this and then
//   holds off input. Reset clears the pending sequence, the queue and the
//   byte index; no clearing pass is needed. When the receiver stalls, the
//   head byte holds and input continues until the queue is full.
// ----------------------------------------------------------------------------
module utf8_sanitizer_core
   import utf8s_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   utf8s_req_if.sink   req_chan,
   utf8s_rsp_if.source rsp_chan
);

   entry_type push_entry;
   logic      push_valid;
   logic      push_ready;
   entry_type head_entry;
   logic      head_valid;
   logic      pop;

   // Classification and sequence tracking.
   utf8s_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // Decoupling queue.
   utf8s_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .pop        (pop)
   );

   // Byte serializer.
   utf8s_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
